// File: rtl/core/apm_pkg.sv
// apm_pkg: shared types and constants for the audio peak/rms/dc meter
// no dependencies
package apm_pkg;
    localparam int MaxChannels = 8;
    localparam int ChBits = 3;
    localparam int SampleBits = 24;
    localparam int FrameBits = 32;
    localparam int SumBits = 56;
    localparam int SqBits = 64;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    localparam logic [3:0] CH_COUNT_RESET = 4'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] channel;
        logic signed [23:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [31:0] frame_count;
        logic [23:0] sample_peak;
        logic [23:0] rms_level;
        logic signed [23:0] dc_offset;
    } t_out_item;

    // classified command from the front part to the back part
    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] channel;
        logic last_ch;
        logic [23:0] mag;
        logic signed [23:0] sample;
    } t_cmd;
endpackage

// File: rtl/core/apm_front.sv
// apm_front: accepts items, drops unused channels, classifies into a two-entry queue
// depends on apm_pkg
module apm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  apm_pkg::t_in_item i_item,
    input  logic [3:0]        i_ch_count,
    output logic              o_cmd_valid,
    output apm_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_take
);
    import apm_pkg::*;

    t_cmd r_q0, r_q1, n_cmd;
    logic [1:0] r_cnt;
    logic [3:0] cnt_eff;
    logic keep, acc;

    assign cnt_eff = (i_ch_count > 4'(MaxChannels)) ? 4'(MaxChannels) : i_ch_count;
    assign o_full = (r_cnt == 2'd2);
    assign acc = i_push && !o_full;

    always_comb begin
        n_cmd.opcode = i_item.opcode;
        n_cmd.channel = i_item.channel;
        n_cmd.sample = i_item.sample;
        n_cmd.mag = i_item.sample[23] ? 24'(-i_item.sample) : 24'(i_item.sample);
        n_cmd.last_ch = ({1'b0, i_item.channel} == cnt_eff - 4'd1);
        case (i_item.opcode)
            OP_SAMPLE: keep = ({1'b0, i_item.channel} < cnt_eff);
            OP_CLEAR: keep = 1'b1;
            OP_REPORT: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({acc && keep, i_cmd_take && o_cmd_valid})
                2'b10: r_cnt <= r_cnt + 2'd1;
                2'b01: r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (i_cmd_take && o_cmd_valid) begin
            r_q0 <= (r_cnt == 2'd2) ? r_q1 : n_cmd;
            if (acc && keep && r_cnt == 2'd2) r_q1 <= n_cmd;
        end else if (acc && keep) begin
            if (r_cnt == 2'd0) r_q0 <= n_cmd;
            else r_q1 <= n_cmd;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (!(acc && keep) || i_cmd_take))
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("bad queue count");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_cmd_valid)
        else $error("valid when empty");
endmodule

// File: rtl/core/apm_back.sv
// apm_back: per-channel stores, report sequencer with serial divide and square root
// depends on apm_pkg
module apm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  apm_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    input  logic [3:0]         i_ch_count,
    output logic               o_res_valid,
    output apm_pkg::t_out_item o_res,
    input  logic               i_res_take
);
    import apm_pkg::*;

    localparam logic [2:0] S_RUN = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DDIV = 3'd2;
    localparam logic [2:0] S_RDIV = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [23:0] r_peak [MaxChannels];
    logic [63:0] r_sq [MaxChannels];
    logic signed [55:0] r_sum [MaxChannels];
    logic [31:0] r_frames;

    logic [2:0] r_state;
    logic [3:0] r_idx;
    logic [6:0] r_bit;
    logic [23:0] r_pk;
    logic [63:0] r_tot;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [35:0] r_den;
    logic r_neg;
    logic [55:0] r_best;
    logic signed [23:0] r_dc;
    logic [63:0] r_root;
    logic [63:0] r_sbit;
    logic r_outv;
    t_out_item r_out;
    logic [3:0] cnt_eff;

    assign cnt_eff = (i_ch_count > 4'(MaxChannels)) ? 4'(MaxChannels) : i_ch_count;
    assign o_cmd_take = i_cmd_valid && (r_state == S_RUN) && !r_outv;
    assign o_res_valid = r_outv;
    assign o_res = r_out;

    logic [2:0] ch;
    logic [47:0] sq;
    logic [64:0] sqsum;
    logic signed [56:0] nsum;
    logic [2:0] si;
    logic [55:0] smag;
    logic [64:0] ttot;
    logic [64:0] trial;
    logic [55:0] dq;
    logic [64:0] rtrial;
    logic [63:0] half;

    assign ch = i_cmd.channel;
    assign sq = 48'(i_cmd.mag) * 48'(i_cmd.mag);
    assign sqsum = {1'b0, r_sq[ch]} + 65'(sq);
    assign nsum = 57'(r_sum[ch]) + 57'(i_cmd.sample);
    assign si = r_idx[2:0];
    assign smag = r_sum[si][55] ? 56'(-r_sum[si]) : 56'(r_sum[si]);
    assign ttot = {1'b0, r_tot} + {1'b0, r_sq[si]};
    assign trial = {r_rem[62:0], r_quo[63]} - {29'd0, r_den};
    // full mean quotient once the last bit is in
    assign dq = {r_quo[54:0], !trial[64]};
    assign rtrial = {1'b0, r_rem} - ({1'b0, r_root} + {1'b0, r_sbit});
    assign half = 64'h800000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_outv <= 1'b0;
            r_frames <= '0;
            for (int i = 0; i < MaxChannels; i++) begin
                r_peak[i] <= '0;
                r_sq[i] <= '0;
                r_sum[i] <= '0;
            end
        end else begin
            if (r_outv && i_res_take) r_outv <= 1'b0;
            case (r_state)
                S_RUN: begin
                    if (o_cmd_take) begin
                        case (i_cmd.opcode)
                            OP_SAMPLE: begin
                                if (i_cmd.mag > r_peak[ch]) r_peak[ch] <= i_cmd.mag;
                                r_sq[ch] <= sqsum[64] ? '1 : sqsum[63:0];
                                if (nsum > 57'sh007FFFFFFFFFFFFF) r_sum[ch] <= 56'sh7FFFFFFFFFFFFF;
                                else if (nsum < -57'sh0080000000000000)
                                    r_sum[ch] <= 56'sh80000000000000;
                                else r_sum[ch] <= nsum[55:0];
                                if (i_cmd.last_ch && r_frames != '1) r_frames <= r_frames + 32'd1;
                            end
                            OP_CLEAR: begin
                                r_frames <= '0;
                                for (int i = 0; i < MaxChannels; i++) begin
                                    r_peak[i] <= '0;
                                    r_sq[i] <= '0;
                                    r_sum[i] <= '0;
                                end
                            end
                            default: begin
                                r_out.frame_count <= r_frames;
                                r_out.sample_peak <= '0;
                                r_out.rms_level <= '0;
                                r_out.dc_offset <= '0;
                                if (r_frames == '0 || cnt_eff == 4'd0) begin
                                    r_outv <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                    r_idx <= '0;
                                    r_pk <= '0;
                                    r_tot <= '0;
                                    r_best <= '0;
                                    r_dc <= '0;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // per channel: peak, total, then divide mean
                    if (r_peak[si] > r_pk) r_pk <= r_peak[si];
                    r_tot <= ttot[64] ? '1 : ttot[63:0];
                    r_neg <= r_sum[si][55];
                    r_quo <= {smag, 8'd0};
                    r_rem <= '0;
                    r_den <= 36'(r_frames);
                    r_bit <= 7'd56;
                    r_state <= S_DDIV;
                end
                S_DDIV, S_RDIV: begin
                    if (r_bit != 7'd1) begin
                        if (!trial[64]) begin
                            r_rem <= trial[63:0];
                            r_quo <= {r_quo[62:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[62:0], r_quo[63]};
                            r_quo <= {r_quo[62:0], 1'b0};
                        end
                        r_bit <= r_bit - 7'd1;
                    end else if (r_state == S_DDIV) begin
                        // strictly larger keeps the lower channel on a tie
                        if (dq > r_best) begin
                            r_best <= dq;
                            if (r_neg)
                                r_dc <= (dq > 56'(half)) ? 24'sh800000 : 24'(-dq);
                            else
                                r_dc <= (dq > 56'(half - 1)) ? 24'sh7FFFFF : 24'(dq);
                        end
                        if (r_idx + 4'd1 == cnt_eff) begin
                            r_state <= S_RDIV;
                            r_quo <= r_tot;
                            r_rem <= '0;
                            r_den <= 36'(r_frames) * 36'(cnt_eff);
                            r_bit <= 7'd64;
                        end else begin
                            r_idx <= r_idx + 4'd1;
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_rem <= {r_quo[62:0], !trial[64]};
                        r_root <= '0;
                        r_sbit <= 64'h4000000000000000;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (!rtrial[64]) begin
                        r_rem <= rtrial[63:0];
                        r_root <= (r_root >> 1) + r_sbit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit[0]) r_state <= S_DONE;
                end
                default: begin
                    r_out.sample_peak <= r_pk;
                    r_out.rms_level <= (r_root > half) ? 24'h800000 : r_root[23:0];
                    r_out.dc_offset <= r_dc;
                    r_outv <= 1'b1;
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> !o_cmd_take)
        else $error("take while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_outv |-> !o_cmd_take)
        else $error("take while result held");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DDIV) |-> (r_idx < 4'(MaxChannels)))
        else $error("channel scan overrun");
endmodule

// File: rtl/core/audio_peak_rms_dc_meter.sv
// audio_peak_rms_dc_meter: top level, apb register, front queue and back sequencer
// depends on apm_pkg, apm_front, apm_back
//
// Sample and clear items are handled in the back part's run state and pass through a
// two-entry command queue, so a sample stream runs at one item per cycle while no report
// result waits. A report item holds the back part for one scan state and a 56-step
// shift-subtract divide per channel for the means, a 64-step divide for the mean square
// and a 32-step square root. The result is held in an output register until popped;
// no new command starts while it waits. channel_count sits at address 0.
module audio_peak_rms_dc_meter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  apm_pkg::t_in_item  i_item,
    output logic               o_empty,
    input  logic               i_pop,
    output apm_pkg::t_out_item o_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import apm_pkg::*;

    logic [3:0] r_ch_count;
    logic cmd_valid, cmd_take, res_valid;
    t_cmd cmd;

    // channel_count register, only address 0 decodes
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {28'd0, r_ch_count} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_count <= CH_COUNT_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_ch_count <= pwdata[3:0];
        end
    end

    apm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_item(i_item), .i_ch_count(r_ch_count), .o_cmd_valid(cmd_valid),
        .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    apm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_take(cmd_take), .i_ch_count(r_ch_count), .o_res_valid(res_valid),
        .o_res(o_item), .i_res_take(i_pop)
    );

    assign o_empty = !res_valid;
endmodule
